@@ design/rphw_pkg.sv @@
// Shared types and constants for the range profile half-power width block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rphw_pkg;

    localparam int COEF_BITS  = 16;
    localparam int INDEX_BITS = 10;
    localparam int RES_BITS   = 36;

    // Speed of light times 128: c / 2 in Q8 before dividing by bandwidth.
    localparam logic [RES_BITS-1:0] C_TIMES_128 = 36'd38373434624;

    // Configuration register indexes.
    localparam logic [1:0] REG_IMAGE_WIDTH = 2'd0;
    localparam logic [1:0] REG_USE_THEORY  = 2'd1;
    localparam logic [1:0] REG_BANDWIDTH   = 2'd2;
    localparam logic [1:0] REG_PIXEL_STEP  = 2'd3;

    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_COEF  = 1'b1;

    typedef struct packed {
        logic                  mode;
        logic [15:0]           pixel_value;
        logic [INDEX_BITS-1:0] coef_index;
        logic [COEF_BITS-1:0]  coef_value;
        logic                  end_of_image;
    } t_in_item;

    typedef struct packed {
        logic [RES_BITS-1:0]   resolution_q8;
        logic [INDEX_BITS-1:0] peak_column;
        logic [INDEX_BITS-1:0] left_edge;
        logic [INDEX_BITS-1:0] right_edge;
        logic                  from_theory;
    } t_out_item;

endpackage

`default_nettype wire

@@ design/rphw_stream_if.sv @@
// Valid/ready stream channel carrying one payload item per transfer.
// Payload type is supplied by the instantiating level.
`timescale 1ns / 1ps
`default_nettype none

interface rphw_stream_if #(parameter type t_payload = logic) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ design/range_profile_halfpower_width.sv @@
// Range profile half-power width.
// Input channel i_in carries pixels (mode 0) in raster order and window
// coefficient writes (mode 1). Each pixel is added into its column sum held in
// a RAM; one pixel or coefficient is taken per cycle while the block is idle.
// The pixel with end_of_image set starts the analysis and stalls the input:
//   zero width: a zero result straight after the drain state,
//   theory mode: a bit-serial divide giving a 36-bit quotient,
//   image mode: a scan of all active columns through the sum and window RAMs
//   and one multiplier, then read, wait, test per left or right walk step.
// The result goes to an output register on o_out; a stalled receiver holds it
// there, and a later result waits until it has been taken.
// After every result, and after reset, a clearing pass writes zero to all
// MAX_COLUMNS column sums, one per cycle; input is held off during the pass.
// Configuration writes on i_cfg_* take effect at once and belong in idle time.
// Reset is synchronous, active low, and restores the register defaults.
// Depends on rphw_pkg, rphw_stream_if and rphw_ram.
`timescale 1ns / 1ps
`default_nettype none

module range_profile_halfpower_width #(
    parameter int MAX_COLUMNS   = 1024,
    parameter int MAX_ROWS_LOG2 = 10,
    parameter int PIXEL_BITS    = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    rphw_stream_if.sink      i_in,
    rphw_stream_if.source    o_out,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);
    import rphw_pkg::*;

    localparam int CW  = $clog2(MAX_COLUMNS);
    localparam int AWW = $clog2(MAX_COLUMNS + 1);
    localparam int WW  = (AWW > 11) ? AWW : 11;
    localparam int SW  = MAX_ROWS_LOG2 + PIXEL_BITS;
    localparam int PW  = SW + COEF_BITS;
    localparam int PB  = (PIXEL_BITS < 16) ? PIXEL_BITS : 16;

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_DRAIN  = 4'd2;
    localparam logic [3:0] S_SCAN   = 4'd3;
    localparam logic [3:0] S_SFLUSH = 4'd4;
    localparam logic [3:0] S_LREAD  = 4'd5;
    localparam logic [3:0] S_LWAIT  = 4'd6;
    localparam logic [3:0] S_LTEST  = 4'd7;
    localparam logic [3:0] S_RREAD  = 4'd8;
    localparam logic [3:0] S_RWAIT  = 4'd9;
    localparam logic [3:0] S_RTEST  = 4'd10;
    localparam logic [3:0] S_DIV    = 4'd11;
    localparam logic [3:0] S_RESULT = 4'd12;

    localparam logic [1:0] K_ZERO   = 2'd0;
    localparam logic [1:0] K_THEORY = 2'd1;
    localparam logic [1:0] K_IMAGE  = 2'd2;

    localparam logic [SW-1:0] SUM_MAX = {SW{1'b1}};

    // Configuration registers
    logic [10:0] r_image_width;
    logic        r_use_theory;
    logic [31:0] r_bandwidth;
    logic [15:0] r_pixel_step;

    logic [3:0]    r_state, n_state;
    logic [CW-1:0] r_col;
    logic [CW-1:0] r_clr;

    // Pixel accumulate stage
    logic          r_p_v;
    logic [CW-1:0] r_p_addr;
    logic [SW-1:0] r_p_pix;
    logic          r_fwd_v;
    logic [CW-1:0] r_fwd_addr;
    logic [SW-1:0] r_fwd_data;

    // Scan and walks
    logic [CW-1:0] r_si, r_si1, r_si2;
    logic          r_sv1, r_sv2;
    logic [PW-1:0] r_prod;
    logic [PW-1:0] r_best;
    logic [CW-1:0] r_pos, r_left, r_right;

    // Divider
    logic [31:0]         r_div;
    logic [31:0]         r_rem;
    logic [RES_BITS-1:0] r_quo;
    logic [5:0]          r_dcnt;

    logic [1:0] r_kind;
    logic       r_out_v;
    t_out_item  r_out;
    t_out_item  n_out;

    // Datapath
    logic [WW-1:0]  act_w, col_ext, col_inc;
    logic [CW-1:0]  col_use, rd_addr;
    logic           in_acc, pix_acc, coef_acc;
    logic [SW-1:0]  sum_rdata, sum_old, sum_new, sum_wdata;
    logic [SW:0]    sum_add;
    logic [COEF_BITS-1:0] coef_rdata;
    logic           sum_we, coef_we;
    logic [CW-1:0]  sum_waddr, coef_waddr;
    logic [31:0]    div_b;
    logic [32:0]    rem_sh;
    logic           rem_ge;
    logic           half_above;
    logic [WW-1:0]  last_col;
    logic [CW+15:0] width_prod;
    t_in_item       in_item;

    assign in_item = i_in.payload;

    always_comb begin
        if ({{(WW-11){1'b0}}, r_image_width} > WW'(MAX_COLUMNS)) begin
            act_w = WW'(MAX_COLUMNS);
        end else begin
            act_w = {{(WW-11){1'b0}}, r_image_width};
        end
    end

    assign last_col = act_w - WW'(1);
    assign col_ext  = {{(WW-CW){1'b0}}, r_col};
    assign col_use  = (col_ext < act_w) ? r_col : '0;
    assign col_inc  = {{(WW-CW){1'b0}}, col_use} + WW'(1);

    assign i_in.ready = (r_state == S_IDLE);
    assign in_acc     = i_in.valid && (r_state == S_IDLE);
    assign pix_acc    = in_acc && (in_item.mode == MODE_PIXEL);
    assign coef_acc   = in_acc && (in_item.mode == MODE_COEF)
                        && ({{(WW-INDEX_BITS){1'b0}}, in_item.coef_index} < WW'(MAX_COLUMNS));

    always_comb begin
        case (r_state)
            S_SCAN:  rd_addr = r_si;
            S_LREAD: rd_addr = r_left;
            S_RREAD: rd_addr = r_right;
            default: rd_addr = col_use;
        endcase
    end

    // Forward the last write when the next pixel hits the same column.
    assign sum_old = (r_fwd_v && (r_fwd_addr == r_p_addr)) ? r_fwd_data : sum_rdata;
    assign sum_add = {1'b0, sum_old} + {1'b0, r_p_pix};
    assign sum_new = sum_add[SW] ? SUM_MAX : sum_add[SW-1:0];

    assign sum_we    = r_p_v || (r_state == S_CLEAR);
    assign sum_waddr = r_p_v ? r_p_addr : r_clr;
    assign sum_wdata = r_p_v ? sum_new : '0;

    assign coef_we    = coef_acc;
    assign coef_waddr = CW'(in_item.coef_index);

    rphw_ram #(.WIDTH(SW), .DEPTH(MAX_COLUMNS)) u_sum_ram (
        .i_clk   (i_clk),
        .i_we    (sum_we),
        .i_waddr (sum_waddr),
        .i_wdata (sum_wdata),
        .i_raddr (rd_addr),
        .o_rdata (sum_rdata)
    );

    rphw_ram #(.WIDTH(COEF_BITS), .DEPTH(MAX_COLUMNS)) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (coef_we),
        .i_waddr (coef_waddr),
        .i_wdata (in_item.coef_value),
        .i_raddr (rd_addr),
        .o_rdata (coef_rdata)
    );

    assign half_above = {r_prod, 1'b0} > {1'b0, r_best};
    assign div_b      = (r_bandwidth == '0) ? 32'd1 : r_bandwidth;
    assign rem_sh     = {r_rem, r_quo[RES_BITS-1]};
    assign rem_ge     = rem_sh >= {1'b0, r_div};
    assign width_prod = (r_right - r_left) * r_pixel_step;

    always_comb begin
        n_out = '0;
        case (r_kind)
            K_THEORY: begin
                n_out.resolution_q8 = r_quo;
                n_out.from_theory   = 1'b1;
            end
            K_IMAGE: begin
                n_out.resolution_q8 = RES_BITS'(width_prod);
                n_out.peak_column   = INDEX_BITS'(r_pos);
                n_out.left_edge     = INDEX_BITS'(r_left);
                n_out.right_edge    = INDEX_BITS'(r_right);
            end
            default: ;
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR:  if (r_clr == CW'(MAX_COLUMNS - 1)) n_state = S_IDLE;
            S_IDLE:   if (pix_acc && in_item.end_of_image) n_state = S_DRAIN;
            S_DRAIN: begin
                if (act_w == '0) begin
                    n_state = S_RESULT;
                end else if (r_use_theory) begin
                    n_state = S_DIV;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN:   if ({{(WW-CW){1'b0}}, r_si} == last_col) n_state = S_SFLUSH;
            S_SFLUSH: if (!r_sv1 && !r_sv2) n_state = S_LREAD;
            S_LREAD:  n_state = S_LWAIT;
            S_LWAIT:  n_state = S_LTEST;
            S_LTEST:  n_state = (r_left != '0 && half_above) ? S_LREAD : S_RREAD;
            S_RREAD:  n_state = S_RWAIT;
            S_RWAIT:  n_state = S_RTEST;
            S_RTEST: begin
                if ({{(WW-CW){1'b0}}, r_right} < last_col && half_above) begin
                    n_state = S_RREAD;
                end else begin
                    n_state = S_RESULT;
                end
            end
            S_DIV:    if (r_dcnt == 6'(RES_BITS - 1)) n_state = S_RESULT;
            S_RESULT: if (!r_out_v) n_state = S_CLEAR;
            default:  n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_clr         <= '0;
            r_col         <= '0;
            r_p_v         <= 1'b0;
            r_fwd_v       <= 1'b0;
            r_sv1         <= 1'b0;
            r_sv2         <= 1'b0;
            r_out_v       <= 1'b0;
            r_kind        <= K_ZERO;
            r_image_width <= 11'd1024;
            r_use_theory  <= 1'b0;
            r_bandwidth   <= 32'd100000000;
            r_pixel_step  <= 16'd128;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_IMAGE_WIDTH: r_image_width <= i_cfg_data[10:0];
                    REG_USE_THEORY:  r_use_theory  <= i_cfg_data[0];
                    REG_BANDWIDTH:   r_bandwidth   <= i_cfg_data;
                    REG_PIXEL_STEP:  r_pixel_step  <= i_cfg_data[15:0];
                    default: ;
                endcase
            end

            r_clr <= (r_state == S_CLEAR) ? r_clr + CW'(1) : '0;

            r_p_v   <= pix_acc && (act_w != '0);
            r_fwd_v <= r_p_v;
            if (pix_acc) begin
                if (in_item.end_of_image) begin
                    r_col <= '0;
                end else if (act_w != '0) begin
                    r_col <= (col_inc >= act_w) ? '0 : CW'(col_inc);
                end
            end

            r_sv1 <= (r_state == S_SCAN);
            r_sv2 <= r_sv1;

            if (r_state == S_DRAIN) begin
                r_kind <= (act_w == '0) ? K_ZERO : (r_use_theory ? K_THEORY : K_IMAGE);
            end

            if (r_state == S_RESULT && !r_out_v) begin
                r_out_v <= 1'b1;
            end else if (o_out.ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_p_addr   <= col_use;
        r_p_pix    <= {{(SW-PB){1'b0}}, in_item.pixel_value[PB-1:0]};
        r_fwd_addr <= r_p_addr;
        r_fwd_data <= sum_new;
        r_prod     <= PW'(sum_rdata * coef_rdata);
        r_si1      <= r_si;
        r_si2      <= r_si1;

        r_si <= (r_state == S_SCAN) ? r_si + CW'(1) : '0;

        // Keep the first column of the largest weighted sum.
        if (r_sv2 && (r_si2 == '0 || r_prod > r_best)) begin
            r_best <= r_prod;
            r_pos  <= r_si2;
        end

        if (r_state == S_SFLUSH) begin
            r_left  <= r_pos;
            r_right <= r_pos;
        end
        if (r_state == S_LTEST && r_left != '0 && half_above) begin
            r_left <= r_left - CW'(1);
        end
        if (r_state == S_RTEST && {{(WW-CW){1'b0}}, r_right} < last_col && half_above) begin
            r_right <= r_right + CW'(1);
        end

        if (r_state == S_DRAIN) begin
            r_div  <= div_b;
            r_rem  <= '0;
            r_quo  <= C_TIMES_128 + {{(RES_BITS-31){1'b0}}, div_b[31:1]};
            r_dcnt <= '0;
        end else if (r_state == S_DIV) begin
            r_rem  <= rem_ge ? 32'(rem_sh - {1'b0, r_div}) : rem_sh[31:0];
            r_quo  <= {r_quo[RES_BITS-2:0], rem_ge};
            r_dcnt <= r_dcnt + 6'd1;
        end

        if (r_state == S_RESULT && !r_out_v) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid   = r_out_v;
    assign o_out.payload = r_out;

    a_pix_stage_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p_v |-> (r_state == S_IDLE || r_state == S_DRAIN))
        else $error("column sum write outside pixel intake");

    a_eoi_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pix_acc && in_item.end_of_image) |=> (r_state == S_DRAIN))
        else $error("end of image did not start analysis");

    a_walk_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LTEST || r_state == S_RTEST) |-> (r_left <= r_pos && r_right >= r_pos))
        else $error("walk edges crossed the peak");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_dcnt < 6'(RES_BITS)))
        else $error("divider ran past its bit count");

    a_no_scan_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sv1 || r_sv2) |-> !i_in.ready)
        else $error("input taken during scan");
endmodule

`default_nettype wire

@@ design/rphw_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module rphw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking bench for range_profile_halfpower_width: pixel and coefficient
// transfers in, windowed half-power width results out, compared with a model.
// Depends on rphw_pkg, rphw_stream_if and the block's RTL.
`timescale 1ns / 1ps

module testbench;
    import rphw_pkg::*;

    localparam int NCOL = 1024;
    localparam int WIN_COLS = 64;
    localparam logic [25:0] SUM_FULL = 26'h3FFFFFF;
    localparam longint LIMIT = 3000000;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [1:0] i_cfg_index;
    logic [31:0] i_cfg_data;

    rphw_stream_if #(.t_payload(t_in_item)) in_ch ();
    rphw_stream_if #(.t_payload(t_out_item)) out_ch ();

    range_profile_halfpower_width i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // Predictor state
    logic [25:0] col_sum [NCOL];
    logic [15:0] win_coef [NCOL];
    int unsigned col_pos;
    logic [10:0] cfg_width;
    logic cfg_theory;
    logic [31:0] cfg_bw;
    logic [15:0] cfg_step;

    t_out_item width_results_due[$];
    int errors = 0;
    int n_results = 0;
    int n_items = 0;
    longint cycle = 0;
    bit idle_off = 0;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_rx = 0;

    logic [31:0] cfg_bw_list [4] = '{32'd0, 32'd1, 32'hFFFFFFFF, 32'd100000000};

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle > LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic logic [41:0] weighted(int i);
        return col_sum[i] * win_coef[i];
    endfunction

    function automatic t_out_item analyse_profile();
        t_out_item r;
        int w, pos, lft, rgt;
        logic [41:0] best;
        longint unsigned b;
        r = '0;
        w = (cfg_width > NCOL) ? NCOL : cfg_width;
        if (w == 0) return r;
        if (cfg_theory) begin
            b = (cfg_bw == 0) ? 1 : cfg_bw;
            r.resolution_q8 = 36'((64'd38373434624 + b / 2) / b);
            r.from_theory = 1'b1;
            return r;
        end
        best = weighted(0);
        pos = 0;
        for (int i = 1; i < w; i++)
            if (weighted(i) > best) begin
                best = weighted(i);
                pos = i;
            end
        lft = pos;
        while (lft > 0 && {weighted(lft), 1'b0} > {1'b0, best}) lft--;
        rgt = pos;
        while (rgt < w - 1 && {weighted(rgt), 1'b0} > {1'b0, best}) rgt++;
        r.resolution_q8 = 36'((rgt - lft) * cfg_step);
        r.peak_column = 10'(pos);
        r.left_edge = 10'(lft);
        r.right_edge = 10'(rgt);
        return r;
    endfunction

    function automatic void predict_item(t_in_item it);
        int w, c;
        logic [26:0] s;
        w = (cfg_width > NCOL) ? NCOL : cfg_width;
        if (it.mode == MODE_COEF) begin
            win_coef[it.coef_index] = it.coef_value;
            return;
        end
        if (w > 0) begin
            c = (col_pos < w) ? col_pos : 0;
            s = col_sum[c] + it.pixel_value;
            col_sum[c] = (s > SUM_FULL) ? SUM_FULL : s[25:0];
            col_pos = (c + 1 >= w) ? 0 : c + 1;
        end
        if (!it.end_of_image) return;
        width_results_due.push_back(analyse_profile());
        for (int i = 0; i < NCOL; i++) col_sum[i] = '0;
        col_pos = 0;
    endfunction

    // Sender
    task automatic send_item(t_in_item it);
        in_ch.valid <= 1'b1;
        in_ch.payload <= it;
        do @(posedge i_clk); while (!in_ch.ready);
        predict_item(it);
        n_items++;
        if (!idle_off && $urandom_range(99) < 7) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task automatic park_sender();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        park_sender();
        while (width_results_due.size() != 0) @(posedge i_clk);
        repeat (2200) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_IMAGE_WIDTH: cfg_width = val[10:0];
            REG_USE_THEORY: cfg_theory = val[0];
            REG_BANDWIDTH: cfg_bw = val;
            default: cfg_step = val[15:0];
        endcase
    endtask

    function automatic t_in_item pixel(logic [15:0] v, logic eoi);
        t_in_item it;
        it = '0;
        it.mode = MODE_PIXEL;
        it.pixel_value = v;
        it.end_of_image = eoi;
        it.coef_index = 10'($urandom);
        it.coef_value = 16'($urandom);
        return it;
    endfunction

    function automatic t_in_item coef(logic [9:0] idx, logic [15:0] v, logic eoi);
        t_in_item it;
        it = '0;
        it.mode = MODE_COEF;
        it.coef_index = idx;
        it.coef_value = v;
        it.end_of_image = eoi;
        it.pixel_value = 16'($urandom);
        return it;
    endfunction

    // Load window coefficients 0 to n - 1, enough for every image width run in image mode.
    task automatic load_window(int n);
        for (int i = 0; i < n; i++)
            send_item(coef(10'(i), 16'($urandom_range(32768)), 1'b0));
    endtask

    task automatic send_image(int w, int rows, bit peaky);
        int pk;
        pk = (w > 0) ? $urandom_range(w - 1) : 0;
        for (int r = 0; r < rows; r++)
            for (int c = 0; c < w; c++)
                send_item(pixel(peaky ? ((c == pk || c == pk + 1) ? 16'hF000
                                : 16'($urandom_range(2000))) : 16'($urandom),
                                (r == rows - 1) && (c == w - 1)));
    endtask

    task automatic test_directed();
        idle_off = 1;
        load_window(WIN_COLS);
        drain();
        write_reg(REG_IMAGE_WIDTH, 32'd4);
        write_reg(REG_PIXEL_STEP, 32'h0000FFFF);
        send_item(pixel(16'hFFFF, 1'b0));
        send_item(pixel(16'h0000, 1'b0));
        send_item(coef(10'd1, 16'hFFFF, 1'b1));   // coefficient with end flag: no result
        send_item(pixel(16'h8000, 1'b0));
        send_item(pixel(16'h7FFF, 1'b1));
        send_item(pixel(16'hFFFF, 1'b1));         // short image: counter restarts
        drain();
        write_reg(REG_IMAGE_WIDTH, 32'd0);
        send_item(pixel(16'h1234, 1'b1));
        drain();
        write_reg(REG_USE_THEORY, 32'd1);
        write_reg(REG_IMAGE_WIDTH, 32'd2);
        foreach (cfg_bw_list[k]) begin
            drain();
            write_reg(REG_BANDWIDTH, cfg_bw_list[k]);
            send_item(pixel(16'h1, 1'b1));
        end
        drain();
        write_reg(REG_USE_THEORY, 32'd0);
        write_reg(REG_PIXEL_STEP, 32'd0);
        send_item(pixel(16'h5, 1'b0));
        send_item(pixel(16'h5, 1'b1));
        drain();
        idle_off = 0;
    endtask

    task automatic test_saturation();
        // Drive column 0 past full scale on a one-column image, then widen to two
        // columns so the peak lands on column 1 only if column 0 saturated.
        drain();
        idle_off = 1;
        write_reg(REG_IMAGE_WIDTH, 32'd1);
        write_reg(REG_PIXEL_STEP, 32'd128);
        send_item(coef(10'd0, 16'd1, 1'b0));
        send_item(coef(10'd1, 16'd1030, 1'b0));
        for (int r = 0; r < 1030; r++) send_item(pixel(16'hFFFF, 1'b0));
        drain();
        write_reg(REG_IMAGE_WIDTH, 32'd2);
        send_item(pixel(16'h0000, 1'b0));
        send_item(pixel(16'd65200, 1'b1));
        drain();
        idle_off = 0;
    endtask

    task automatic test_backpressure();
        drain();
        write_reg(REG_IMAGE_WIDTH, 32'd4);
        write_reg(REG_USE_THEORY, 32'd0);
        write_reg(REG_PIXEL_STEP, 32'd128);
        // Stall the receiver long so the block backs up on its input.
        hold_req++;
        send_image(4, 2, 1'b1);
        send_image(4, 1, 1'b0);
        send_image(4, 1, 1'b0);
        drain();
    endtask

    task automatic test_random_images();
        int w;
        bit th;
        drain();
        while (n_items < 1600) begin
            drain();
            w = $urandom_range(1, 24);
            if ($urandom_range(4) == 0) w = $urandom_range(25, WIN_COLS);
            th = ($urandom_range(9) == 0);
            // A width above the column count reads the whole window; keep it to theory mode.
            if ($urandom_range(14) == 0) begin
                w = $urandom_range(1025, 2047);
                th = 1'b1;
            end
            if ($urandom_range(19) == 0) w = 0;
            write_reg(REG_IMAGE_WIDTH, 32'(w));
            write_reg(REG_PIXEL_STEP, $urandom);
            write_reg(REG_USE_THEORY, {31'd0, th});
            write_reg(REG_BANDWIDTH, $urandom);
            if ($urandom_range(4) == 0)
                send_item(coef(10'($urandom), 16'($urandom), 1'($urandom)));
            if (w == 0)
                send_item(pixel(16'($urandom), 1'b1));
            else
                send_image((w > NCOL) ? 8 : w, $urandom_range(1, 3), 1'($urandom_range(1)));
        end
    endtask

    // Receiver and checker
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (hold_seen != hold_req) begin
                hold_seen <= hold_req;
                hold_rx <= 3000;
                out_ch.ready <= 1'b0;
            end else if (hold_rx > 0) begin
                hold_rx <= hold_rx - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= idle_off || ($urandom_range(99) >= 7);
            end
            if (out_ch.valid && out_ch.ready) begin
                n_results++;
                if (width_results_due.size() == 0) begin
                    errors++;
                    $display("%0t unexpected result %p", $time, out_ch.payload);
                end else if (out_ch.payload !== width_results_due[0]) begin
                    errors++;
                    $display("%0t mismatch: expected %p actual %p", $time,
                             width_results_due[0], out_ch.payload);
                    void'(width_results_due.pop_front());
                end else begin
                    void'(width_results_due.pop_front());
                end
            end
        end
    end

    initial begin
        i_rst_n = 0;
        i_cfg_we = 0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        in_ch.valid = 0;
        in_ch.payload = '0;
        cfg_width = 1024;
        cfg_theory = 0;
        cfg_bw = 100000000;
        cfg_step = 128;
        col_pos = 0;
        for (int i = 0; i < NCOL; i++) begin
            col_sum[i] = '0;
            win_coef[i] = '0;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_saturation();
        test_backpressure();
        test_random_images();
        drain();
        $display("covered %0d input transfers and %0d results over width, step,",
                 n_items, n_results);
        $display("theory and bandwidth settings, saturation and output back-pressure");
        if (errors == 0 && width_results_due.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
